// File: design/rtu_pkg.sv
// shared types, constants and crc function for the rtu frame checker
package rtu_pkg;

  localparam logic [15:0] CRC_SEED        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  ADDR_LIMIT      = 8'd248;
  localparam logic [8:0]  MIN_FRAME_BYTES = 9'd4;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_CRC   = 3'd1,
    ST_ADDR  = 3'd2,
    ST_SHORT = 3'd3,
    ST_LONG  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_done;
    status_e    status;
    logic [7:0] slave_address;
    logic [7:0] func_code;
    logic [7:0] payload_length;
  } result_t;

  // reflected crc-16, one byte folded in bit by bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/rtu_if.sv
// valid/ready channel interfaces for received bytes and check results
interface rtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       frame_done;
  logic [2:0] status;
  logic [7:0] slave_address;
  logic [7:0] func_code;
  logic [7:0] payload_length;

  modport source (output valid, output data_byte, output data_valid, output frame_done,
                  output status, output slave_address, output func_code,
                  output payload_length, input ready);
  modport sink (input valid, input data_byte, input data_valid, input frame_done,
                input status, input slave_address, input func_code,
                input payload_length, output ready);
endinterface

// File: design/rtu_frame_checker.sv
// rtu frame checker: payload extraction and crc/address/length check of serial frames
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   rx_byte[7:0], frame_end
//   out_o    out  valid/ready   data_byte, data_valid, frame_done, status,
//                               slave_address, func_code, payload_length
//
// one item is taken per cycle while the queue has room; its results land in the
// result queue in the same edge and can leave in the next cycle
// the crc update is one byte through an unrolled 8-step fold between the frame state
// and the 4-entry result queue; that queue sets the rate: items are taken while it
// has room for two results, so with the output always taken one item goes per cycle
// reset (rst_ni low) empties the queue and restarts the frame state
module rtu_frame_checker #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  rtu_in_if.sink    in_i,
  rtu_out_if.source out_o
);
  import rtu_pkg::*;

  // byte counter holds 0 .. MAX_FRAME_BYTES
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int QD    = 4;

  // frame state
  logic [7:0]       dly0_q, dly0_d;   // previous byte
  logic [7:0]       dly1_q, dly1_d;   // byte before that
  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       code_q, code_d;
  logic             ovl_q, ovl_d;

  // result queue
  result_t    q_mem [QD];
  logic [1:0] wr_q, rd_q;
  logic [2:0] fill_q;

  logic       in_fire, out_fire;
  logic       over, push_data, push_stat;
  logic [8:0] n_ext;
  logic [7:0] plen;
  logic [15:0] rx_crc;
  status_e    st;
  result_t    data_res, stat_res, head;
  logic [1:0] n_push;

  // take an item only while two free slots remain
  assign in_i.ready = (fill_q <= 3'(QD - 2));
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // frame state update and result building
  always_comb begin
    dly0_d    = dly0_q;
    dly1_d    = dly1_q;
    crc_d     = crc_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    code_d    = code_q;
    ovl_d     = ovl_q;
    push_data = 1'b0;
    over      = (cnt_q >= CNT_W'(MAX_FRAME_BYTES));

    if (over) begin
      // byte beyond the length limit is dropped
      ovl_d = 1'b1;
    end else begin
      if (cnt_q == '0) begin
        addr_d = in_i.rx_byte;
      end
      if (cnt_q == CNT_W'(1)) begin
        code_d = in_i.rx_byte;
      end
      if (cnt_q >= CNT_W'(2)) begin
        // oldest byte leaves the delay line into the crc
        crc_d = crc_feed(crc_q, dly1_q);
        if (cnt_q >= CNT_W'(4)) begin
          push_data = 1'b1;
        end
      end
      if (!in_i.frame_end) begin
        dly1_d = dly0_q;
        dly0_d = in_i.rx_byte;
      end
      cnt_d = cnt_q + CNT_W'(1);
    end

    // end-of-frame status
    n_ext  = 9'(cnt_d);
    plen   = (n_ext >= MIN_FRAME_BYTES) ? 8'(n_ext - MIN_FRAME_BYTES) : 8'd0;
    rx_crc = {in_i.rx_byte, dly0_q};
    if (n_ext < MIN_FRAME_BYTES) begin
      st = ST_SHORT;
    end else if (ovl_d) begin
      st = ST_LONG;
    end else if (rx_crc != crc_d) begin
      st = ST_CRC;
    end else if (addr_d >= ADDR_LIMIT) begin
      st = ST_ADDR;
    end else begin
      st = ST_OK;
    end

    data_res                = '0;
    data_res.data_byte      = dly1_q;
    data_res.data_valid     = 1'b1;
    data_res.status         = ST_OK;

    stat_res                = '0;
    stat_res.frame_done     = 1'b1;
    stat_res.status         = st;
    stat_res.slave_address  = addr_d;
    stat_res.func_code      = code_d;
    stat_res.payload_length = plen;

    push_stat = in_i.frame_end;

    // frame closed: back to the start state
    if (in_i.frame_end) begin
      dly0_d = '0;
      dly1_d = '0;
      crc_d  = CRC_SEED;
      cnt_d  = '0;
      addr_d = '0;
      code_d = '0;
      ovl_d  = 1'b0;
    end
  end

  assign n_push = in_fire ? ({1'b0, push_data} + {1'b0, push_stat}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly0_q <= '0;
      dly1_q <= '0;
      crc_q  <= CRC_SEED;
      cnt_q  <= '0;
      addr_q <= '0;
      code_q <= '0;
      ovl_q  <= 1'b0;
    end else if (in_fire) begin
      dly0_q <= dly0_d;
      dly1_q <= dly1_d;
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      addr_q <= addr_d;
      code_q <= code_d;
      ovl_q  <= ovl_d;
    end
  end

  // queue storage: payload item first, status item behind it
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (push_data) begin
        q_mem[wr_q] <= data_res;
        if (push_stat) begin
          q_mem[wr_q + 2'd1] <= stat_res;
        end
      end else if (push_stat) begin
        q_mem[wr_q] <= stat_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + n_push;
      rd_q   <= rd_q + {1'b0, out_fire};
      fill_q <= fill_q + {1'b0, n_push} - {2'b00, out_fire};
    end
  end

  assign head                 = q_mem[rd_q];
  assign out_o.valid          = (fill_q != 3'd0);
  assign out_o.data_byte      = head.data_byte;
  assign out_o.data_valid     = head.data_valid;
  assign out_o.frame_done     = head.frame_done;
  assign out_o.status         = head.status;
  assign out_o.slave_address  = head.slave_address;
  assign out_o.func_code      = head.func_code;
  assign out_o.payload_length = head.payload_length;

endmodule

// File: tb/sv/rtu_result_checker.sv
// result checker: predicts the items of the rtu frame checker and compares them at its output
module rtu_result_checker #(
  parameter int MaxFrameBytes = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  rtu_in_if    in_mon,
  rtu_out_if   out_mon,
  output int   pending_o,
  output int   mismatches_o,
  output int   frames_o,
  output int   payload_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtu_pkg::*;

  // items still owed by the block, oldest first
  result_t     due_results[$];

  // frame state of the prediction
  logic [7:0]  held_bytes[2];
  logic [15:0] crc_acc;
  logic [8:0]  bytes_in;
  logic [7:0]  addr_byte;
  logic [7:0]  code_byte;
  logic        too_long;

  task automatic clear_frame();
    held_bytes[0] = '0;
    held_bytes[1] = '0;
    crc_acc       = CRC_SEED;
    bytes_in      = '0;
    addr_byte     = '0;
    code_byte     = '0;
    too_long      = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [7:0] b;
    logic       last;
    status_e    st;
    result_t    want;
    result_t    item;
    if (!rst_ni) begin
      due_results.delete();
      clear_frame();
      pending_o = 0;
    end else begin
      // output first: an item's results never leave in the cycle it is taken
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected item: data_byte %0h, frame_done %0b, status %0d",
                 out_mon.data_byte, out_mon.frame_done, out_mon.status);
          mismatches_o++;
        end else begin
          want = due_results.pop_front();
          check_field("data_byte", want.data_byte, out_mon.data_byte);
          check_field("data_valid", 8'(want.data_valid), 8'(out_mon.data_valid));
          check_field("frame_done", 8'(want.frame_done), 8'(out_mon.frame_done));
          check_field("status", 8'(want.status), 8'(out_mon.status));
          check_field("slave_address", want.slave_address, out_mon.slave_address);
          check_field("func_code", want.func_code, out_mon.func_code);
          check_field("payload_length", want.payload_length, out_mon.payload_length);
          if (want.frame_done) frames_o++;
          else payload_o++;
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        b    = in_mon.rx_byte;
        last = in_mon.frame_end;
        if (bytes_in >= MaxFrameBytes) begin
          too_long = 1'b1;
        end else begin
          if (bytes_in == 0) addr_byte = b;
          if (bytes_in == 1) code_byte = b;
          if (bytes_in >= 2) begin
            // byte leaving the two-deep delay goes into the crc
            crc_acc ^= {8'h00, held_bytes[1]};
            repeat (8) crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
            if (bytes_in >= MIN_FRAME_BYTES) begin
              item            = '0;
              item.data_byte  = held_bytes[1];
              item.data_valid = 1'b1;
              due_results.push_back(item);
            end
          end
          if (!last) begin
            held_bytes[1] = held_bytes[0];
            held_bytes[0] = b;
          end
          bytes_in++;
        end

        if (last) begin
          if (bytes_in < MIN_FRAME_BYTES) st = ST_SHORT;
          else if (too_long) st = ST_LONG;
          else if ({b, held_bytes[0]} != crc_acc) st = ST_CRC;
          else if (addr_byte >= ADDR_LIMIT) st = ST_ADDR;
          else st = ST_OK;
          item                = '0;
          item.frame_done     = 1'b1;
          item.status         = st;
          item.slave_address  = addr_byte;
          item.func_code      = code_byte;
          item.payload_length = (bytes_in >= MIN_FRAME_BYTES) ?
                                8'(bytes_in - MIN_FRAME_BYTES) : 8'd0;
          due_results.push_back(item);
          clear_frame();
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

// File: tb/sv/tb_rtu_frame_checker.sv
// testbench top: feeds serial frames to the rtu frame checker and reports the verdict
module tb_rtu_frame_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import rtu_pkg::*;

  localparam int MAX_FRAME   = 256;
  localparam int ITEM_GOAL   = 1050;  // bytes to send before the random part stops
  localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int LONG_HOLD   = 60;    // receiver hold-off, fills the result queue
  localparam int HOLD_AT     = 150;   // results taken before the long hold starts
  localparam int SETTLE      = 10;    // quiet cycles after the last expected result

  logic clk_i;
  logic rst_ni;

  rtu_in_if  in_if ();
  rtu_out_if out_if ();

  int pending;
  int mismatches;
  int frames_seen;
  int payload_seen;
  int bytes_sent;
  int frames_sent;
  int results_taken;
  bit tx_burst;
  bit rx_burst;

  rtu_frame_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  rtu_result_checker #(
    .MaxFrameBytes(MAX_FRAME)
  ) u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .pending_o   (pending),
    .mismatches_o(mismatches),
    .frames_o    (frames_seen),
    .payload_o   (payload_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one byte: optional idle gap with noise on the lines, then hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid     = 1'b0;
      in_if.rx_byte   = 8'($urandom);
      in_if.frame_end = 1'($urandom);
    end
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.rx_byte   = b;
    in_if.frame_end = last;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  // builds address, code, payload and crc (low byte first); cut > 0 keeps only
  // the first cut bytes, fill >= 0 gives every payload byte that value
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] code, input int plen,
                            input bit bad_crc, input int cut = 0, input int fill = -1);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    frame = {addr, code};
    repeat (plen) frame.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    crc = CRC_SEED;
    foreach (frame[i]) begin
      crc ^= {8'h00, frame[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    // a single flipped bit is the hardest error for the comparison to miss
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    if (cut > 0) begin
      while (frame.size() > cut) void'(frame.pop_back());
    end
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    frames_sent++;
  endtask

  // drop valid and wait until every expected item has come out
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: random hold-off per item, calm stretches, and one long hold
  // that lets the result queue fill so the block stops taking bytes
  initial begin : receiver
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 4);
      if (results_taken == HOLD_AT) gap = LONG_HOLD;
      repeat (gap) begin
        @(negedge clk_i);
        out_if.ready = 1'b0;
      end
      @(negedge clk_i);
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      results_taken++;
    end
  end

  // watchdog: ends the run if nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $error("no item moved for %0d cycles, %0d items still expected", STALL_LIMIT, pending);
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    int         kind;
    int         nframe;
    logic [7:0] addr;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    in_if.frame_end = 1'b0;
    tx_burst        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // too-short frames of one, two and three bytes, the first two with address and code at extremes
    send_frame(8'h00, 8'h00, 0, 1'b0, 1);
    send_frame(8'hFF, 8'hFF, 0, 1'b0, 2);
    send_frame(8'h5A, 8'h03, 1, 1'b0, 3);
    // shortest well-formed frame, nothing to pass through
    send_frame(8'h01, 8'h03, 0, 1'b0);
    // highest legal address, all-zero payload byte
    send_frame(8'd247, 8'h10, 1, 1'b0, 0, 8'h00);
    // first illegal address with a good crc, all-ones payload byte
    send_frame(8'd248, 8'h7F, 1, 1'b0, 0, 8'hFF);
    // crc mismatch wins over a bad address
    send_frame(8'hFF, 8'h80, 0, 1'b1);
    pause_until_drained();

    // random frames: mostly well-formed with short payloads, some broken
    nframe = 0;
    while (bytes_sent < ITEM_GOAL) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      addr = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(248, 255))
                                          : 8'($urandom_range(0, 247));
      if (nframe == 8) begin
        // exactly the longest frame allowed, crc still checked
        send_frame(addr, 8'($urandom), MAX_FRAME - 4, 1'($urandom));
      end else if (nframe == 16) begin
        // runs past the limit, tail bytes dropped
        send_frame(addr, 8'($urandom), MAX_FRAME, 1'($urandom));
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 8) send_frame(addr, 8'($urandom), 1, 1'b0, $urandom_range(1, 3));
        else send_frame(addr, 8'($urandom), $urandom_range(0, 12), kind < 30);
      end
      // sender goes quiet once mid-run until the block has emptied out
      if (nframe == 24) pause_until_drained();
      nframe++;
    end

    pause_until_drained();
    repeat (SETTLE) @(negedge clk_i);
    $display("run covered %0d frames, %0d bytes in, %0d payload and %0d status items checked",
             frames_sent, bytes_sent, payload_seen, frames_seen);
    $display("frames were short, bad-crc, high-address, full-length and overlong as well as good");
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
